// ===== rtl/core/svs_pkg.sv =====
// Shared types and constants for the scan validity segmenter.
// Depends on nothing; every other file of the block imports it.
package svs_pkg;

   // Widths of the result fields.
   localparam int SEG_POS_W   = 10;
   localparam int SEG_LEN_W   = 11;
   localparam int SHORT_LEN_W = 4;

   // Reset value of the short-length register.
   localparam logic [SHORT_LEN_W-1:0] SHORT_LEN_RESET = 4'd3;

   // A scan needs this many points before a partition can be reported.
   localparam int MIN_POINTS = 3;

   // Result queue geometry.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // One input beat.
   typedef struct packed {
      logic undefined_flag;
      logic last_point;
   } req_item_type;

   // Registered input beat handed to the segmenter core.
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } in_beat_type;

   // One result beat.
   typedef struct packed {
      logic                 seg_valid;
      logic [SEG_POS_W-1:0] seg_index;
      logic [SEG_POS_W-1:0] seg_start;
      logic [SEG_POS_W-1:0] seg_end;
      logic                 seg_undefined;
      logic [SEG_LEN_W-1:0] seg_length;
      logic [SEG_LEN_W-1:0] match_count;
      logic                 overflow;
      logic                 last_result;
   } rsp_item_type;

   // Results produced by one point: a closed partition, the final one, or both.
   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

endpackage

// ===== rtl/core/svs_if.sv =====
// Handshake interfaces for the request and result channels.
// Depends on svs_pkg for the result field widths.
interface svs_req_if;
   logic valid;
   logic ready;
   logic undefined_flag;
   logic last_point;

   modport source (output valid, undefined_flag, last_point, input ready);
   modport sink (input valid, undefined_flag, last_point, output ready);
endinterface

interface svs_rsp_if import svs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 seg_valid;
   logic [SEG_POS_W-1:0] seg_index;
   logic [SEG_POS_W-1:0] seg_start;
   logic [SEG_POS_W-1:0] seg_end;
   logic                 seg_undefined;
   logic [SEG_LEN_W-1:0] seg_length;
   logic [SEG_LEN_W-1:0] match_count;
   logic                 overflow;
   logic                 last_result;

   modport source (output valid, seg_valid, seg_index, seg_start, seg_end, seg_undefined,
                   seg_length, match_count, overflow, last_result, input ready);
   modport sink (input valid, seg_valid, seg_index, seg_start, seg_end, seg_undefined,
                 seg_length, match_count, overflow, last_result, output ready);
endinterface

// ===== rtl/core/svs_in_stage.sv =====
// Input register of the segmenter and the request-side flow control.
// Depends on svs_pkg and svs_req_if.
module svs_in_stage
   import svs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   svs_req_if.sink              req_chan,
   input  logic [RSP_CNT_W-1:0] rsp_level,
   output in_beat_type          in_beat
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type item_ff;
   logic [RSP_CNT_W:0] reserved;
   logic         accept;

   // A beat is taken only when the result queue has room for the two results
   // that the registered point and the new point may each produce.
   always_comb begin
      reserved = {1'b0, rsp_level} + (in_valid_ff ? (RSP_CNT_W+1)'(2) : '0);
      req_chan.ready = (reserved <= (RSP_CNT_W+1)'(RSP_DEPTH - 2));
   end

   assign accept      = req_chan.valid & req_chan.ready;
   assign in_valid_in = accept;

   // Control bit of the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload of the input register.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.undefined_flag <= req_chan.undefined_flag;
         item_ff.last_point     <= req_chan.last_point;
      end
   end

   assign in_beat.valid = in_valid_ff;
   assign in_beat.item  = item_ff;

endmodule

// ===== rtl/core/svs_core.sv =====
// Segmenter state and the per-point decision with two points of lookahead.
// Depends on svs_pkg; fed by svs_in_stage, feeds svs_rsp_fifo.
module svs_core
   import svs_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [SHORT_LEN_W-1:0] csr_wr_data,
   input  in_beat_type            in_beat,
   output rsp_push_type           rsp_push
);

   localparam int PCW = $clog2(MAX_POINTS + 1);
   localparam int CW  = (PCW > SHORT_LEN_W) ? PCW : SHORT_LEN_W;

   logic [SHORT_LEN_W-1:0] short_len_ff;
   logic [PCW-1:0]         pc_ff, pc_in;
   logic [1:0]             la_ff, la_in;
   logic                   cs_ff, cs_in;
   logic [PCW-1:0]         start_ff, start_in;
   logic [PCW-1:0]         len_ff, len_in;
   logic [PCW-1:0]         match_ff, match_in;
   logic [SEG_POS_W-1:0]   part_ff, part_in;
   logic                   ovf_ff, ovf_in;

   logic                   flag;
   logic                   in_range;
   logic                   close;
   logic [PCW-1:0]         fin_match;
   rsp_item_type           close_item;
   rsp_item_type           final_item;

   assign flag     = in_beat.item.undefined_flag;
   assign in_range = (pc_ff < PCW'(MAX_POINTS));

   // Decide the point two places back, using the two newest points as lookahead.
   always_comb begin
      pc_in    = pc_ff;
      la_in    = la_ff;
      cs_in    = cs_ff;
      start_in = start_ff;
      len_in   = len_ff;
      match_in = match_ff;
      part_in  = part_ff;
      ovf_in   = ovf_ff;
      close    = 1'b0;
      if (in_beat.valid) begin
         if (in_range) begin
            if (pc_ff == '0) begin
               cs_in    = flag;
               start_in = '0;
               len_in   = PCW'(1);
               match_in = PCW'(1);
               part_in  = '0;
            end else if (pc_ff >= PCW'(MIN_POINTS)) begin
               if (la_ff[1] == cs_ff) begin
                  len_in   = len_ff + PCW'(1);
                  match_in = match_ff + PCW'(1);
               end else if ((la_ff[0] != cs_ff) && (flag != cs_ff)) begin
                  if (CW'(len_ff) < CW'(short_len_ff)) begin
                     // Too short to stand alone: the partition takes the new state.
                     cs_in    = ~cs_ff;
                     match_in = PCW'(1);
                     len_in   = len_ff + PCW'(1);
                  end else begin
                     close    = 1'b1;
                     part_in  = part_ff + SEG_POS_W'(1);
                     cs_in    = ~cs_ff;
                     start_in = pc_ff - PCW'(2);
                     len_in   = PCW'(1);
                     match_in = PCW'(1);
                  end
               end else begin
                  // One or two opposing points are absorbed without counting.
                  len_in = len_ff + PCW'(1);
               end
            end
            la_in = {la_ff[0], flag};
            pc_in = pc_ff + PCW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // Result for a partition closed by this point.
   always_comb begin
      close_item.seg_valid     = 1'b1;
      close_item.seg_index     = part_ff;
      close_item.seg_start     = SEG_POS_W'(start_ff);
      close_item.seg_end       = SEG_POS_W'(pc_ff - PCW'(3));
      close_item.seg_undefined = cs_ff;
      close_item.seg_length    = SEG_LEN_W'(len_ff);
      close_item.match_count   = SEG_LEN_W'(match_ff);
      close_item.overflow      = ovf_ff;
      close_item.last_result   = 1'b0;
   end

   // Final result of the scan; the last two points join the open partition.
   always_comb begin
      fin_match = match_in + PCW'(la_in[1] == cs_in) + PCW'(la_in[0] == cs_in);
      if (pc_in < PCW'(MIN_POINTS)) begin
         final_item             = '0;
         final_item.last_result = 1'b1;
      end else begin
         final_item.seg_valid     = 1'b1;
         final_item.seg_index     = part_in;
         final_item.seg_start     = SEG_POS_W'(start_in);
         final_item.seg_end       = SEG_POS_W'(pc_in - PCW'(1));
         final_item.seg_undefined = cs_in;
         final_item.seg_length    = SEG_LEN_W'(pc_in - start_in);
         final_item.match_count   = SEG_LEN_W'(fin_match);
         final_item.overflow      = ovf_in;
         final_item.last_result   = 1'b1;
      end
   end

   // Order the results: a closed partition always comes before the final one.
   always_comb begin
      rsp_push.push0 = in_beat.valid & (close | in_beat.item.last_point);
      rsp_push.push1 = in_beat.valid & close & in_beat.item.last_point;
      rsp_push.item0 = close ? close_item : final_item;
      rsp_push.item1 = final_item;
   end

   // Short-length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         short_len_ff <= SHORT_LEN_RESET;
      end else if (csr_wr_en) begin
         short_len_ff <= csr_wr_data;
      end
   end

   // Scan state; it clears after the last point so the next beat opens a new scan.
   always_ff @(posedge clock) begin
      if (reset || (in_beat.valid && in_beat.item.last_point)) begin
         pc_ff    <= '0;
         la_ff    <= '0;
         cs_ff    <= 1'b0;
         start_ff <= '0;
         len_ff   <= '0;
         match_ff <= '0;
         part_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         pc_ff    <= pc_in;
         la_ff    <= la_in;
         cs_ff    <= cs_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         match_ff <= match_in;
         part_ff  <= part_in;
         ovf_ff   <= ovf_in;
      end
   end

`ifndef SYNTH
   // The second slot is used only behind a closed partition, as the final result.
   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      rsp_push.push1 |-> (rsp_push.push0 && !rsp_push.item0.last_result
                          && rsp_push.item1.last_result))
      else $error("second result without a closed partition ahead of it");

   // The point counter never passes the scan limit.
   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PCW'(MAX_POINTS))
      else $error("point counter beyond the scan limit");

   // A last point leaves the block ready for point zero of a new scan.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (in_beat.valid && in_beat.item.last_point) |=> (pc_ff == '0 && !ovf_ff))
      else $error("scan state not cleared after the last point");

   // Overflow can only be flagged once the scan is full.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (pc_ff == PCW'(MAX_POINTS)))
      else $error("overflow flagged on a scan that is not full");
`endif

endmodule

// ===== rtl/core/svs_rsp_fifo.sv =====
// Result queue: takes up to two results a cycle and drives the result channel.
// Depends on svs_pkg and svs_rsp_if.
module svs_rsp_fifo
   import svs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  rsp_push_type         rsp_push,
   svs_rsp_if.source            rsp_chan,
   output logic [RSP_CNT_W-1:0] rsp_level
);

   rsp_item_type         mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_PTR_W-1:0] wr_ptr_next;
   logic [1:0]           push_num;
   logic                 pop;
   rsp_item_type         head;

   assign pop         = rsp_chan.valid & rsp_chan.ready;
   assign push_num    = {1'b0, rsp_push.push0} + {1'b0, rsp_push.push1};
   assign wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);

   // Pointer and level bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_num);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push_num) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage; the second result lands right behind the first.
   always_ff @(posedge clock) begin
      if (rsp_push.push0) begin
         mem_ff[wr_ptr_ff] <= rsp_push.item0;
      end
      if (rsp_push.push1) begin
         mem_ff[wr_ptr_next] <= rsp_push.item1;
      end
   end

   // Head of the queue drives the result beat.
   assign head                   = mem_ff[rd_ptr_ff];
   assign rsp_chan.valid         = (count_ff != '0);
   assign rsp_chan.seg_valid     = head.seg_valid;
   assign rsp_chan.seg_index     = head.seg_index;
   assign rsp_chan.seg_start     = head.seg_start;
   assign rsp_chan.seg_end       = head.seg_end;
   assign rsp_chan.seg_undefined = head.seg_undefined;
   assign rsp_chan.seg_length    = head.seg_length;
   assign rsp_chan.match_count   = head.match_count;
   assign rsp_chan.overflow      = head.overflow;
   assign rsp_chan.last_result   = head.last_result;
   assign rsp_level              = count_ff;

`ifndef SYNTH
   // Flow control upstream must keep the queue from overfilling.
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (RSP_CNT_W+1)'(count_ff) + (RSP_CNT_W+1)'(push_num) <= (RSP_CNT_W+1)'(RSP_DEPTH))
      else $error("result queue overfilled");

   // The level moves exactly by pushes minus pops.
   a_level_track: assert property (@(posedge clock) disable iff (reset)
      ##1 (count_ff == $past(count_ff) + RSP_CNT_W'($past(push_num)) - RSP_CNT_W'($past(pop))))
      else $error("result queue level out of step");

   // The read and write pointers stay consistent with the level.
   a_ptr_level: assert property (@(posedge clock) disable iff (reset)
      (RSP_PTR_W'(wr_ptr_ff - rd_ptr_ff) == RSP_PTR_W'(count_ff)))
      else $error("result queue pointers disagree with level");
`endif

endmodule

// ===== rtl/core/scan_validity_segmenter_top.sv =====
// Scan validity segmenter: one scan point per beat in, one result beat per
// partition out. The block takes a point in every cycle; each point is
// registered, and in the next cycle it completes the lookahead for the point two
// places before it, which is then decided against the open partition. The
// results enter an eight-deep result queue. A point that both closes a partition
// and ends the scan yields two result beats. The request side pauses only while
// the result queue lacks room for two results from each point in flight, which
// happens only when the result side stalls. The user must write the short-length
// register through csr_wr_en / csr_wr_data only between scans; the block itself
// does not enforce this.
// Depends on svs_pkg, svs_if, svs_in_stage, svs_core and svs_rsp_fifo.
module scan_validity_segmenter_top
   import svs_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [SHORT_LEN_W-1:0] csr_wr_data,
   svs_req_if.sink                req_chan,
   svs_rsp_if.source              rsp_chan
);

   in_beat_type          in_beat;
   rsp_push_type         rsp_push;
   logic [RSP_CNT_W-1:0] rsp_level;

   // Input register and request flow control.
   svs_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_level (rsp_level),
      .in_beat   (in_beat)
   );

   // Partition decision and scan state.
   svs_core #(
      .MAX_POINTS (MAX_POINTS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_beat     (in_beat),
      .rsp_push    (rsp_push)
   );

   // Result queue.
   svs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_chan  (rsp_chan),
      .rsp_level (rsp_level)
   );

endmodule

// ===== tb/tb_scan_validity_segmenter_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for scan_validity_segmenter_top: random scans in,
// partition results checked against a behavioral partition tracker.
// Depends on svs_pkg, svs_if and the segmenter RTL.
module tb_scan_validity_segmenter_top;
   import svs_pkg::*;

   localparam int SCAN_MAX    = 1024;
   localparam int ITEM_TARGET = 1350;
   localparam int PHASES      = 8;
   localparam int STALL_LIMIT = 2000;
   // The over-limit scan takes most of the budget; random scans get half the rest.
   localparam int PHASE_POINTS = (ITEM_TARGET - SCAN_MAX) / (2 * PHASES);

   // Tracks the open partition of the current scan and holds the partitions
   // the block still owes us, oldest first.
   class partition_tracker;
      bit [SHORT_LEN_W-1:0] short_len;
      bit [SEG_LEN_W-1:0]   point_cnt;
      bit [1:0]             recent_flags;
      bit                   cur_undef;
      bit [SEG_POS_W-1:0]   open_start;
      bit [SEG_LEN_W-1:0]   open_len;
      bit [SEG_LEN_W-1:0]   open_match;
      bit [SEG_POS_W-1:0]   part_idx;
      bit                   ovf_seen;
      rsp_item_type         pending_parts[$];
      int                   error_count;

      function new();
         short_len   = SHORT_LEN_RESET;
         error_count = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         point_cnt    = '0;
         recent_flags = '0;
         cur_undef    = 1'b0;
         open_start   = '0;
         open_len     = '0;
         open_match   = '0;
         part_idx     = '0;
         ovf_seen     = 1'b0;
      endfunction

      function void push_part(bit valid, bit [SEG_POS_W-1:0] idx, bit [SEG_POS_W-1:0] start,
                              bit [SEG_POS_W-1:0] stop, bit undef, bit [SEG_LEN_W-1:0] len,
                              bit [SEG_LEN_W-1:0] match, bit ovf, bit fin);
         rsp_item_type part;
         part.seg_valid     = valid;
         part.seg_index     = idx;
         part.seg_start     = start;
         part.seg_end       = stop;
         part.seg_undefined = undef;
         part.seg_length    = len;
         part.match_count   = match;
         part.overflow      = ovf;
         part.last_result   = fin;
         pending_parts.push_back(part);
      endfunction

      // Account for one accepted point. A point is decided once the two
      // points after it have arrived, so a state change needs three
      // opposing points in a row.
      function void note_point(bit flag, bit is_last);
         bit [SEG_LEN_W-1:0] k;
         bit [SEG_LEN_W-1:0] match;
         if (point_cnt < SCAN_MAX) begin
            k = point_cnt;
            if (k == 0) begin
               cur_undef  = flag;
               open_start = '0;
               open_len   = SEG_LEN_W'(1);
               open_match = SEG_LEN_W'(1);
               part_idx   = '0;
            end else if (k >= 3) begin
               if (recent_flags[1] == cur_undef) begin
                  open_len++;
                  open_match++;
               end else if (recent_flags[0] != cur_undef && flag != cur_undef) begin
                  if (open_len < short_len) begin
                     // Too short to stand alone: relabel it to the new state.
                     cur_undef  = ~cur_undef;
                     open_match = SEG_LEN_W'(1);
                     open_len++;
                  end else begin
                     push_part(1'b1, part_idx, open_start, SEG_POS_W'(k - 3), cur_undef,
                               open_len, open_match, ovf_seen, 1'b0);
                     part_idx++;
                     cur_undef  = ~cur_undef;
                     open_start = SEG_POS_W'(k - 2);
                     open_len   = SEG_LEN_W'(1);
                     open_match = SEG_LEN_W'(1);
                  end
               end else begin
                  // One or two opposing points are absorbed.
                  open_len++;
               end
            end
            recent_flags = {recent_flags[0], flag};
            point_cnt    = k + SEG_LEN_W'(1);
         end else begin
            ovf_seen = 1'b1;
         end

         if (is_last) begin
            if (point_cnt < MIN_POINTS) begin
               push_part(1'b0, '0, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
            end else begin
               // The last two points always join the final partition.
               match = open_match + SEG_LEN_W'(recent_flags[1] == cur_undef)
                       + SEG_LEN_W'(recent_flags[0] == cur_undef);
               push_part(1'b1, part_idx, open_start, SEG_POS_W'(point_cnt - 1), cur_undef,
                         SEG_LEN_W'(point_cnt - open_start), match, ovf_seen, 1'b1);
            end
            clear_scan();
         end
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
         end
      endfunction

      // Compare one result beat with the oldest partition owed.
      function void check_part(rsp_item_type got);
         rsp_item_type want;
         if (pending_parts.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
            error_count++;
            return;
         end
         want = pending_parts.pop_front();
         check_field("seg_valid", 32'(want.seg_valid), 32'(got.seg_valid));
         check_field("seg_index", 32'(want.seg_index), 32'(got.seg_index));
         check_field("seg_start", 32'(want.seg_start), 32'(got.seg_start));
         check_field("seg_end", 32'(want.seg_end), 32'(got.seg_end));
         check_field("seg_undefined", 32'(want.seg_undefined), 32'(got.seg_undefined));
         check_field("seg_length", 32'(want.seg_length), 32'(got.seg_length));
         check_field("match_count", 32'(want.match_count), 32'(got.match_count));
         check_field("overflow", 32'(want.overflow), 32'(got.overflow));
         check_field("last_result", 32'(want.last_result), 32'(got.last_result));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [SHORT_LEN_W-1:0] csr_wr_data;

   svs_req_if req_if ();
   svs_rsp_if rsp_if ();

   partition_tracker tracker = new();

   int req_gap_max  = 16;
   int rsp_gap_max  = 16;
   int points_sent  = 0;
   int stall_cycles = 0;

   scan_validity_segmenter_top #(.MAX_POINTS(SCAN_MAX)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   // 10 ns clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle cycles before a beat: often none, otherwise up to the phase maximum.
   function automatic int draw_gap(int max_gap);
      if (max_gap == 0) return 0;
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, max_gap) : 0;
   endfunction

   // Offer one point and wait for it to be taken. Valid stays high on return
   // so that a following point can go out back to back.
   task automatic send_point(input bit flag, input bit is_last);
      int gap;
      gap = draw_gap(req_gap_max);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.undefined_flag <= flag;
      req_if.last_point     <= is_last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.note_point(flag, is_last);
      points_sent++;
   endtask

   // Hold the request side off until every owed result has come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_parts.size() != 0) @(posedge clock);
   endtask

   // Register writes happen only with the block idle and its pipeline empty.
   task automatic write_short_len(input bit [SHORT_LEN_W-1:0] value);
      drain_results();
      repeat (6) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.short_len = value;
   endtask

   // A fixed point pattern, oldest point in the top used bit.
   task automatic send_pattern(input bit [31:0] flags, input int len, input int pause_at);
      for (int i = 0; i < len; i++) begin
         if (i == pause_at) drain_results();
         send_point(flags[len-1-i], i == len - 1);
      end
   endtask

   // A random scan: runs of equal flags of random length, or plain noise.
   task automatic send_scan(input int len, input bit noisy, input int pause_at);
      bit flag;
      int run_left;
      flag     = 1'($urandom_range(0, 1));
      run_left = 0;
      for (int i = 0; i < len; i++) begin
         if (i == pause_at) drain_results();
         if (noisy) begin
            flag = 1'($urandom_range(0, 1));
         end else begin
            if (run_left == 0) begin
               if (i > 0) flag = ~flag;
               run_left = $urandom_range(0, 1) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            end
            run_left--;
         end
         send_point(flag, i == len - 1);
      end
   endtask

   // Result side: random back-pressure, every beat checked.
   initial begin
      rsp_item_type got;
      int           gap;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_gap_max);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         got.seg_valid     = rsp_if.seg_valid;
         got.seg_index     = rsp_if.seg_index;
         got.seg_start     = rsp_if.seg_start;
         got.seg_end       = rsp_if.seg_end;
         got.seg_undefined = rsp_if.seg_undefined;
         got.seg_length    = rsp_if.seg_length;
         got.match_count   = rsp_if.match_count;
         got.overflow      = rsp_if.overflow;
         got.last_result   = rsp_if.last_result;
         tracker.check_part(got);
      end
   end

   // Watchdog: give up when no beat or register write moves for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          csr_wr_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, stall_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Stimulus.
   initial begin
      bit [SHORT_LEN_W-1:0] setting;
      int                   phase_base;
      int                   len;
      int                   pick;
      int                   pause_at;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_if.valid          = 1'b0;
      req_if.undefined_flag = 1'b0;
      req_if.last_point     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: short scans of one and two points, the three-point
      // minimum, absorbed and accepted changes with a pause mid-scan, and a
      // one-point opening partition that gets relabeled.
      send_pattern(32'b1, 1, -1);
      send_pattern(32'b01, 2, -1);
      send_pattern(32'b001, 3, -1);
      send_pattern(32'b0001100011111, 13, 6);
      send_pattern(32'b10000, 5, -1);

      // Random phases, each under its own short-length setting and idle mix.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       setting = '0;
            1:       setting = '1;
            2:       setting = SHORT_LEN_W'(1);
            3:       setting = SHORT_LEN_RESET;
            default: setting = SHORT_LEN_W'($urandom_range(0, 15));
         endcase
         write_short_len(setting);
         req_gap_max = (ph % 3 == 1) ? 0 : 16;
         rsp_gap_max = (ph % 4 == 2) ? 0 : 16;

         // One scan that fills the point limit and runs past it.
         if (ph == 5) send_scan(SCAN_MAX + $urandom_range(1, 5), 1'b0, -1);

         phase_base = points_sent;
         while (points_sent - phase_base < PHASE_POINTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      len = $urandom_range(1, 24);
            else if (pick < 95) len = $urandom_range(25, 60);
            else                len = $urandom_range(61, 120);
            pause_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : -1;
            send_scan(len, $urandom_range(0, 4) == 0, pause_at);
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (tracker.error_count == 0 && tracker.pending_parts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (tracker.pending_parts.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     tracker.pending_parts.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/svs_pkg.sv
rtl/core/svs_if.sv
rtl/core/svs_in_stage.sv
rtl/core/svs_core.sv
rtl/core/svs_rsp_fifo.sv
rtl/core/scan_validity_segmenter_top.sv
tb/tb_scan_validity_segmenter_top.sv
